>>> hw/rtl/adfp_pkg.sv
// adfp_pkg: shared types and constants for the advertising data field parser
// status codes, parse phase codes, AD type codes and the field size limit
// no dependencies
package adfp_pkg;

	typedef logic [1:0] status_t;
	typedef logic [1:0] phase_t;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_TRUNC = 2'd1;
	localparam status_t ST_BAD   = 2'd2;

	localparam phase_t PH_LEN  = 2'd0;
	localparam phase_t PH_TYPE = 2'd1;
	localparam phase_t PH_DATA = 2'd2;

	// largest data length accepted in one structure
	localparam logic [7:0] MAX_FIELD_SIZE = 8'd29;

	// length byte values that are never legal
	localparam logic [7:0] LEN_ZERO = 8'd0;
	localparam logic [7:0] LEN_MAX  = 8'd255;

	// AD type codes
	localparam logic [7:0] AD_FLAGS        = 8'h01;
	localparam logic [7:0] AD_UUID16_PART  = 8'h02;
	localparam logic [7:0] AD_UUID16_FULL  = 8'h03;
	localparam logic [7:0] AD_UUID32_PART  = 8'h04;
	localparam logic [7:0] AD_UUID32_FULL  = 8'h05;
	localparam logic [7:0] AD_UUID128_PART = 8'h06;
	localparam logic [7:0] AD_UUID128_FULL = 8'h07;
	localparam logic [7:0] AD_TX_POWER     = 8'h0A;
	localparam logic [7:0] AD_CLASS_OF_DEV = 8'h0D;
	localparam logic [7:0] AD_CONN_INTERVAL = 8'h12;
	localparam logic [7:0] AD_SVC_DATA16   = 8'h16;
	localparam logic [7:0] AD_TARGET_ADDR  = 8'h17;
	localparam logic [7:0] AD_APPEARANCE   = 8'h19;
	localparam logic [7:0] AD_ADV_INTERVAL = 8'h1A;
	localparam logic [7:0] AD_DEV_ADDR     = 8'h1B;
	localparam logic [7:0] AD_LE_ROLE      = 8'h1C;
	localparam logic [7:0] AD_SVC_DATA32   = 8'h20;
	localparam logic [7:0] AD_SVC_DATA128  = 8'h21;

	// reciprocal for divide by six: (d * 171) >> 10 is exact for d below 256
	localparam logic [7:0] RECIP6       = 8'd171;
	localparam int         RECIP6_SHIFT = 10;

endpackage

>>> hw/rtl/adfp_field_check.sv
// adfp_field_check: length checks on a completed AD structure
// gives status, scalar value and list element count
// depends on adfp_pkg
module adfp_field_check (
	input  logic [7:0]       ad_type,
	input  logic [7:0]       len,
	input  logic [15:0]      accum,
	output adfp_pkg::status_t status,
	output logic [15:0]      value,
	output logic [6:0]       count
);

	logic [15:0] prod6;
	logic [7:0]  quot6;
	logic        ok;
	logic [15:0] val_raw;
	logic [6:0]  cnt_raw;

	assign prod6 = {8'd0, len} * {8'd0, adfp_pkg::RECIP6};
	assign quot6 = {2'd0, prod6[15:adfp_pkg::RECIP6_SHIFT]};

	always_comb begin
		ok      = 1'b1;
		val_raw = 16'd0;
		cnt_raw = 7'd0;
		case (ad_type) inside
			adfp_pkg::AD_FLAGS, adfp_pkg::AD_TX_POWER, adfp_pkg::AD_LE_ROLE: begin
				ok      = (len == 8'd1);
				val_raw = {8'd0, accum[7:0]};
			end
			adfp_pkg::AD_UUID16_PART, adfp_pkg::AD_UUID16_FULL: begin
				ok      = (len[0] == 1'b0);
				cnt_raw = len[7:1];
			end
			adfp_pkg::AD_UUID32_PART, adfp_pkg::AD_UUID32_FULL: begin
				ok      = (len[1:0] == 2'd0);
				cnt_raw = {1'b0, len[7:2]};
			end
			adfp_pkg::AD_UUID128_PART, adfp_pkg::AD_UUID128_FULL: begin
				ok      = (len[3:0] == 4'd0);
				cnt_raw = {3'd0, len[7:4]};
			end
			adfp_pkg::AD_CLASS_OF_DEV:  ok = (len == 8'd3);
			adfp_pkg::AD_CONN_INTERVAL: ok = (len == 8'd4);
			adfp_pkg::AD_SVC_DATA16:    ok = (len >= 8'd2);
			adfp_pkg::AD_TARGET_ADDR: begin
				ok      = ({2'd0, quot6[5:0], 1'b0} + {quot6[6:0], 2'b00} == {1'b0, len});
				cnt_raw = quot6[6:0];
			end
			adfp_pkg::AD_APPEARANCE, adfp_pkg::AD_ADV_INTERVAL: begin
				ok      = (len == 8'd2);
				val_raw = accum;
			end
			adfp_pkg::AD_DEV_ADDR:     ok = (len == 8'd7);
			adfp_pkg::AD_SVC_DATA32:   ok = (len >= 8'd4);
			adfp_pkg::AD_SVC_DATA128:  ok = (len >= 8'd16);
			default:                   ok = 1'b1;
		endcase
		if (len > adfp_pkg::MAX_FIELD_SIZE) begin
			ok = 1'b0;
		end
	end

	assign status = ok ? adfp_pkg::ST_OK : adfp_pkg::ST_BAD;
	assign value  = ok ? val_raw : 16'd0;
	assign count  = ok ? cnt_raw : 7'd0;

endmodule

>>> hw/rtl/adv_data_field_parser.sv
// adv_data_field_parser: streaming parser for advertising data structures
// walks length, type and data bytes and reports one result per structure
// depends on adfp_pkg and adfp_field_check
//
// usage
//   input channel: data_byte and last_byte with in_valid / in_ready; one
//   byte of the advertising buffer per item, last_byte marks the final byte
//   output channel: field_type, field_len, status, field_value, elem_count and
//   end_of_data with out_valid / out_ready; one item per finished structure,
//   per bad length byte, or per buffer that ends inside a structure
//   result timing: a result is registered and shows on the outputs in the
//   cycle after the byte that completes it is accepted
//   throughput: one byte per cycle while in_ready is high; the parse state
//   and the field check sit between the parse registers and the result
//   register, so every cycle with in_ready high can take a byte
//   stall: the result register holds its item while out_ready is low; a new
//   byte is still taken as long as the result register is empty or being
//   drained in the same cycle
//   reset: arst_n low clears the parser to expect a length byte and empties
//   the result register
//   after a bad structure bytes are dropped without results up to the last
//   byte, which returns the parser to its reset state
module adv_data_field_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        field_type,
	output logic [7:0]        field_len,
	output logic [1:0]        status,
	output logic [15:0]       field_value,
	output logic [6:0]        elem_count,
	output logic              end_of_data
);

	// parse state
	adfp_pkg::phase_t phase_q, phase_d;
	logic [7:0]       left_q, left_d;
	logic [7:0]       flen_q, flen_d;
	logic [7:0]       type_q, type_d;
	logic [15:0]      accum_q, accum_d;
	logic             err_q, err_d;

	// result register
	logic             out_valid_q;
	logic [7:0]       res_type_q;
	logic [7:0]       res_len_q;
	adfp_pkg::status_t res_status_q;
	logic [15:0]      res_value_q;
	logic [6:0]       res_count_q;
	logic             res_end_q;

	// result of the current byte
	logic             emit;
	logic [7:0]       r_type;
	logic [7:0]       r_len;
	adfp_pkg::status_t r_status;
	logic [15:0]      r_value;
	logic [6:0]       r_count;

	logic             accept;
	logic [7:0]       idx;
	logic [7:0]       left_dec;
	logic [15:0]      accum_upd;
	logic [7:0]       chk_type;
	logic [15:0]      chk_accum;
	adfp_pkg::status_t chk_status;
	logic [15:0]      chk_value;
	logic [6:0]       chk_count;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// position of this byte inside the data part
	assign idx      = flen_q - left_q;
	assign left_dec = left_q - 8'd1;

	// first two data bytes collect little endian
	always_comb begin
		accum_upd = accum_q;
		if (idx == 8'd0) begin
			accum_upd = {accum_q[15:8], data_byte};
		end else if (idx == 8'd1) begin
			accum_upd = {data_byte, accum_q[7:0]};
		end
	end

	// in the type phase the type byte itself ends a zero length structure
	assign chk_type  = (phase_q == adfp_pkg::PH_TYPE) ? data_byte : type_q;
	assign chk_accum = (phase_q == adfp_pkg::PH_DATA) ? accum_upd : accum_q;

	adfp_field_check u_check (
		.ad_type (chk_type),
		.len     (flen_q),
		.accum   (chk_accum),
		.status  (chk_status),
		.value   (chk_value),
		.count   (chk_count)
	);

	always_comb begin
		phase_d  = phase_q;
		left_d   = left_q;
		flen_d   = flen_q;
		type_d   = type_q;
		accum_d  = accum_q;
		err_d    = err_q;
		emit     = 1'b0;
		r_type   = 8'd0;
		r_len    = 8'd0;
		r_status = adfp_pkg::ST_OK;
		r_value  = 16'd0;
		r_count  = 7'd0;

		if (err_q) begin
			// drop bytes until the end of the buffer
			if (last_byte) begin
				err_d = 1'b0;
			end
		end else begin
			case (phase_q)
				adfp_pkg::PH_LEN: begin
					if (data_byte == adfp_pkg::LEN_ZERO || data_byte == adfp_pkg::LEN_MAX) begin
						emit     = 1'b1;
						r_status = adfp_pkg::ST_BAD;
						err_d    = !last_byte;
					end else begin
						flen_d  = data_byte - 8'd1;
						type_d  = 8'd0;
						accum_d = 16'd0;
						if (last_byte) begin
							emit     = 1'b1;
							r_len    = data_byte - 8'd1;
							r_status = adfp_pkg::ST_TRUNC;
							flen_d   = 8'd0;
						end else begin
							phase_d = adfp_pkg::PH_TYPE;
						end
					end
				end
				adfp_pkg::PH_TYPE: begin
					type_d = data_byte;
					if (flen_q == 8'd0) begin
						emit     = 1'b1;
						r_type   = chk_type;
						r_len    = flen_q;
						r_status = chk_status;
						r_value  = chk_value;
						r_count  = chk_count;
						phase_d  = adfp_pkg::PH_LEN;
						left_d   = 8'd0;
						type_d   = 8'd0;
						accum_d  = 16'd0;
						err_d    = !last_byte && (chk_status != adfp_pkg::ST_OK);
					end else if (last_byte) begin
						emit     = 1'b1;
						r_type   = data_byte;
						r_len    = flen_q;
						r_status = adfp_pkg::ST_TRUNC;
						phase_d  = adfp_pkg::PH_LEN;
						type_d   = 8'd0;
						flen_d   = 8'd0;
					end else begin
						left_d  = flen_q;
						phase_d = adfp_pkg::PH_DATA;
					end
				end
				adfp_pkg::PH_DATA: begin
					if (left_q != 8'd0) begin
						accum_d = accum_upd;
						left_d  = left_dec;
						if (left_dec == 8'd0) begin
							emit     = 1'b1;
							r_type   = chk_type;
							r_len    = flen_q;
							r_status = chk_status;
							r_value  = chk_value;
							r_count  = chk_count;
							phase_d  = adfp_pkg::PH_LEN;
							type_d   = 8'd0;
							accum_d  = 16'd0;
							err_d    = !last_byte && (chk_status != adfp_pkg::ST_OK);
						end else if (last_byte) begin
							emit     = 1'b1;
							r_type   = type_q;
							r_len    = flen_q;
							r_status = adfp_pkg::ST_TRUNC;
						end
					end else begin
						phase_d = adfp_pkg::PH_LEN;
						left_d  = 8'd0;
					end
				end
				default: begin
					// unused phase code falls back to the length phase
					phase_d = adfp_pkg::PH_LEN;
					left_d  = 8'd0;
				end
			endcase
		end

		// the last byte always leaves the parser in its reset state
		if (last_byte) begin
			phase_d = adfp_pkg::PH_LEN;
			left_d  = 8'd0;
			flen_d  = 8'd0;
			type_d  = 8'd0;
			accum_d = 16'd0;
			err_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= adfp_pkg::PH_LEN;
			left_q  <= 8'd0;
			flen_q  <= 8'd0;
			type_q  <= 8'd0;
			accum_q <= 16'd0;
			err_q   <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			left_q  <= left_d;
			flen_q  <= flen_d;
			type_q  <= type_d;
			accum_q <= accum_d;
			err_q   <= err_d;
		end
	end

	// result register: loads on a byte that causes a result, empties when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			res_type_q   <= r_type;
			res_len_q    <= r_len;
			res_status_q <= r_status;
			res_value_q  <= r_value;
			res_count_q  <= r_count;
			res_end_q    <= last_byte;
		end
	end

	assign out_valid   = out_valid_q;
	assign field_type  = res_type_q;
	assign field_len   = res_len_q;
	assign status      = res_status_q;
	assign field_value = res_value_q;
	assign elem_count  = res_count_q;
	assign end_of_data = res_end_q;

endmodule
